// ===== src/bqp_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquadratic patch package
// Shared weight and result formats, pipeline load controls and the rounding
// shift used by the weight, row-sum and final-sum stages of the patch unit.
// ----------------------------------------------------------------------------
package bqp_pkg;

  localparam int WGT_BITS = 16;
  localparam int OUT_FRAC = 8;
  localparam int OUT_BITS = 26;
  localparam int WGT_W    = 20;
  localparam int ROW_HEAD = WGT_W - (WGT_BITS - OUT_FRAC) + 1;
  localparam int ACC_HEAD = WGT_W + ROW_HEAD - 1;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef logic signed [WGT_W-1:0]    wgt_t;
  typedef logic signed [OUT_BITS-1:0] res_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_load_t;

  // Arithmetic right shift that rounds to nearest, with ties toward plus infinity.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int sh);
    logic signed [64:0] v2;
    logic signed [64:0] q;
    v2 = 65'(v);
    v2 = v2 <<< 1;
    q  = (v2 >>> sh) + 65'sd1;
    q  = q >>> 1;
    return q[63:0];
  endfunction

endpackage

// ===== src/bqp_axis_weights.sv =====
// ----------------------------------------------------------------------------
// Axis weights
// Quadratic Lagrange weights of the curve through three samples and their
// derivatives for one patch coordinate, rounded to the shared weight format.
// ----------------------------------------------------------------------------
module bqp_axis_weights import bqp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic [FRAC_BITS:0] pos,
  output wgt_t               wgt [3],
  output wgt_t               drv [3]
);

  localparam int TW = FRAC_BITS + 5;
  localparam int PW = 2 * TW;
  localparam int SH = 2 * FRAC_BITS - WGT_BITS;

  localparam logic signed [TW-1:0] ONE =
    {{(TW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [TW-1:0] t_s;
  logic signed [TW-1:0] a;
  logic signed [TW-1:0] b;
  logic signed [TW-1:0] c;
  logic signed [TW-1:0] dd0;
  logic signed [TW-1:0] dd1;
  logic signed [TW-1:0] dd2;
  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [PW-1:0] q0;
  logic signed [PW-1:0] q1;
  logic signed [PW-1:0] q2;

  always_comb begin
    t_s = TW'(pos);
    a   = ONE - t_s;
    b   = ONE - (t_s <<< 1);
    c   = (t_s <<< 1) - ONE;
    dd0 = (t_s <<< 2) - ONE - (ONE <<< 1);
    dd1 = (ONE <<< 2) - (t_s <<< 3);
    dd2 = (t_s <<< 2) - ONE;
    p0  = PW'(a) * PW'(b);
    p1  = (PW'(t_s) * PW'(a)) <<< 2;
    p2  = PW'(t_s) * PW'(c);
    q0  = PW'(dd0) <<< FRAC_BITS;
    q1  = PW'(dd1) <<< FRAC_BITS;
    q2  = PW'(dd2) <<< FRAC_BITS;
    wgt[0] = WGT_W'(rnd_shift(64'(p0), SH));
    wgt[1] = WGT_W'(rnd_shift(64'(p1), SH));
    wgt[2] = WGT_W'(rnd_shift(64'(p2), SH));
    drv[0] = WGT_W'(rnd_shift(64'(q0), SH));
    drv[1] = WGT_W'(rnd_shift(64'(q1), SH));
    drv[2] = WGT_W'(rnd_shift(64'(q2), SH));
  end

endmodule

// ===== src/bqp_row_filter.sv =====
// ----------------------------------------------------------------------------
// Row filter
// Weights the three columns of every window row: one register stage of
// products, then one stage of row sums rounded to eight fraction bits.
// ----------------------------------------------------------------------------
module bqp_row_filter import bqp_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  pipe_load_t                                load,
  input  wgt_t                                      cw [3],
  input  logic [SAMPLE_BITS-1:0]                    smp [9],
  output logic signed [SAMPLE_BITS+ROW_HEAD-1:0]    row_r [3]
);

  localparam int PR    = SAMPLE_BITS + WGT_W;
  localparam int RW    = PR + 2;
  localparam int ROW_W = SAMPLE_BITS + ROW_HEAD;

  logic signed [PR-1:0]    prod_nxt [9];
  logic signed [PR-1:0]    prod_r   [9];
  logic signed [RW-1:0]    rsum     [3];
  logic signed [ROW_W-1:0] row_nxt  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[3*r+c] = PR'(cw[c]) * PR'($signed({1'b0, smp[3*r+c]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r]    = RW'(prod_r[3*r]) + RW'(prod_r[3*r+1]) + RW'(prod_r[3*r+2]);
      row_nxt[r] = ROW_W'(rnd_shift(64'(rsum[r]), WGT_BITS - OUT_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/bqp_row_combine.sv =====
// ----------------------------------------------------------------------------
// Row combiner
// Weights the three row sums: one register stage of products, then one stage
// that sums, rounds to eight fraction bits, saturates to res_t and clears if !keep.
// ----------------------------------------------------------------------------
module bqp_row_combine import bqp_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  pipe_load_t                             load,
  input  wgt_t                                   rw [3],
  input  logic signed [SAMPLE_BITS+ROW_HEAD-1:0] row [3],
  input  logic                                   keep,
  output res_t                                   res_r
);

  localparam int AW = SAMPLE_BITS + ACC_HEAD;

  logic signed [AW-1:0] prod_nxt [3];
  logic signed [AW-1:0] prod_r   [3];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] q;
  res_t                 sat;
  res_t                 res_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[r] = AW'(rw[r]) * AW'(row[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (load.s4) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    acc = prod_r[0] + prod_r[1] + prod_r[2];
    q   = AW'(rnd_shift(64'(acc), WGT_BITS));
    if (q > AW'(OUT_MAX)) begin
      sat = OUT_MAX;
    end else if (q < AW'(OUT_MIN)) begin
      sat = OUT_MIN;
    end else begin
      sat = q[OUT_BITS-1:0];
    end
    res_nxt = keep ? sat : '0;
  end

  always_ff @(posedge clk) begin
    if (load.s5) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/biquadratic_patch_value_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// Biquadratic patch value and gradient unit
// Fits a biquadratic Lagrange surface through a 3x3 sample window and returns
// the surface value and both partial derivatives at a position in the patch.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | in_sample_r0c0..r2c2, in_frac_x, in_frac_y
//   out     | out_valid, out_stall| out_surface_value, out_grad_x, out_grad_y,
//           |                     | out_valid_res
//
// The unit takes one transfer per cycle while in_stall is low, and registers
// each result in turn after the axis weights, column products, row sums, row
// products, and the final sum with rounding and saturation.
// Reset clears the stage valid bits only.
// Each stage holds while the next one is full and stalled, so empty stages
// close up and the input keeps moving until the whole pipeline is full.
// ----------------------------------------------------------------------------
module biquadratic_patch_value_gradient_unit import bqp_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_r0c0,
  input  logic [SAMPLE_BITS-1:0] in_sample_r0c1,
  input  logic [SAMPLE_BITS-1:0] in_sample_r0c2,
  input  logic [SAMPLE_BITS-1:0] in_sample_r1c0,
  input  logic [SAMPLE_BITS-1:0] in_sample_r1c1,
  input  logic [SAMPLE_BITS-1:0] in_sample_r1c2,
  input  logic [SAMPLE_BITS-1:0] in_sample_r2c0,
  input  logic [SAMPLE_BITS-1:0] in_sample_r2c1,
  input  logic [SAMPLE_BITS-1:0] in_sample_r2c2,
  input  logic [FRAC_BITS:0]     in_frac_x,
  input  logic [FRAC_BITS:0]     in_frac_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output res_t                   out_surface_value,
  output res_t                   out_grad_x,
  output res_t                   out_grad_y,
  output logic                   out_valid_res
);

  localparam int ROW_W = SAMPLE_BITS + ROW_HEAD;
  localparam logic [FRAC_BITS:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  logic rdy5;
  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic v4_r;
  logic v5_r;

  pipe_load_t ld;

  logic [SAMPLE_BITS-1:0] smp_nxt [9];
  logic [SAMPLE_BITS-1:0] smp_r   [9];
  wgt_t                   wx_nxt  [3];
  wgt_t                   dx_nxt  [3];
  wgt_t                   wy_nxt  [3];
  wgt_t                   dy_nxt  [3];
  wgt_t                   wx_r    [3];
  wgt_t                   dx_r    [3];
  wgt_t                   wy_r    [3];
  wgt_t                   dy_r    [3];
  wgt_t                   wy2_r   [3];
  wgt_t                   dy2_r   [3];
  wgt_t                   wy3_r   [3];
  wgt_t                   dy3_r   [3];
  logic                   inr_nxt;
  logic                   inr1_r;
  logic                   inr2_r;
  logic                   inr3_r;
  logic                   inr4_r;
  logic                   vres_r;

  logic signed [ROW_W-1:0] row_w [3];
  logic signed [ROW_W-1:0] row_d [3];

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign ld   = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

  assign in_stall = !rdy1;

  always_comb begin
    smp_nxt[0] = in_sample_r0c0;
    smp_nxt[1] = in_sample_r0c1;
    smp_nxt[2] = in_sample_r0c2;
    smp_nxt[3] = in_sample_r1c0;
    smp_nxt[4] = in_sample_r1c1;
    smp_nxt[5] = in_sample_r1c2;
    smp_nxt[6] = in_sample_r2c0;
    smp_nxt[7] = in_sample_r2c1;
    smp_nxt[8] = in_sample_r2c2;
    inr_nxt    = (in_frac_x <= POS_ONE) && (in_frac_y <= POS_ONE);
  end

  bqp_axis_weights #(.FRAC_BITS(FRAC_BITS)) u_wgt_x (
    .pos (in_frac_x),
    .wgt (wx_nxt),
    .drv (dx_nxt)
  );

  bqp_axis_weights #(.FRAC_BITS(FRAC_BITS)) u_wgt_y (
    .pos (in_frac_y),
    .wgt (wy_nxt),
    .drv (dy_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      smp_r  <= smp_nxt;
      wx_r   <= wx_nxt;
      dx_r   <= dx_nxt;
      wy_r   <= wy_nxt;
      dy_r   <= dy_nxt;
      inr1_r <= inr_nxt;
    end
    if (rdy2) begin
      wy2_r  <= wy_r;
      dy2_r  <= dy_r;
      inr2_r <= inr1_r;
    end
    if (rdy3) begin
      wy3_r  <= wy2_r;
      dy3_r  <= dy2_r;
      inr3_r <= inr2_r;
    end
    if (rdy4) begin
      inr4_r <= inr3_r;
    end
    if (rdy5) begin
      vres_r <= inr4_r;
    end
  end

  bqp_row_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_row_w (
    .clk   (clk),
    .load  (ld),
    .cw    (wx_r),
    .smp   (smp_r),
    .row_r (row_w)
  );

  bqp_row_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_row_d (
    .clk   (clk),
    .load  (ld),
    .cw    (dx_r),
    .smp   (smp_r),
    .row_r (row_d)
  );

  bqp_row_combine #(.SAMPLE_BITS(SAMPLE_BITS)) u_val (
    .clk   (clk),
    .load  (ld),
    .rw    (wy3_r),
    .row   (row_w),
    .keep  (inr4_r),
    .res_r (out_surface_value)
  );

  bqp_row_combine #(.SAMPLE_BITS(SAMPLE_BITS)) u_gx (
    .clk   (clk),
    .load  (ld),
    .rw    (wy3_r),
    .row   (row_d),
    .keep  (inr4_r),
    .res_r (out_grad_x)
  );

  bqp_row_combine #(.SAMPLE_BITS(SAMPLE_BITS)) u_gy (
    .clk   (clk),
    .load  (ld),
    .rw    (dy3_r),
    .row   (row_w),
    .keep  (inr4_r),
    .res_r (out_grad_y)
  );

  assign out_valid     = v5_r;
  assign out_valid_res = vres_r;

endmodule

// ===== src/bqp_checker.sv =====
// ----------------------------------------------------------------------------
// Patch unit checker
// Watches the ports of the patch unit for pipeline flow, latency and the
// cleared fields of results at positions outside the patch.
// ----------------------------------------------------------------------------
module bqp_checker import bqp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input res_t out_surface_value,
  input res_t out_grad_x,
  input res_t out_grad_y,
  input logic out_valid_res
);

  a_zero_when_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_surface_value == '0 && out_grad_x == '0 && out_grad_y == '0)
    else $error("result outside the patch has nonzero fields");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output is free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("transfer did not reach the output in five cycles");

  a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_surface_value) &&
      $stable(out_grad_x) && $stable(out_grad_y) && $stable(out_valid_res))
    else $error("stalled result changed");

endmodule

bind biquadratic_patch_value_gradient_unit bqp_checker u_bqp_checker (.*);
